/* design/rfdm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rfdm_pkg: shared definitions for the RGBA frame difference metrics block
// Holds the field widths, limits, register indexes, controller states and
// the command, status and result structures.
// ----------------------------------------------------------------------------
package rfdm_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int DIM_W     = 13;
    localparam int POS_W     = 12;
    localparam int CNT_W     = 25;
    localparam int SUM_W     = 35;
    localparam int PIX_W     = 25;
    localparam int DIV_NUM_W = 41;
    localparam int QUOT_W    = 17;
    localparam int DIV_STEPS = DIV_NUM_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W = 2;

    localparam logic [QUOT_W-1:0] MEAN_MAX  = QUOT_W'(65280);
    localparam logic [QUOT_W-1:0] RATIO_MAX = QUOT_W'(65536);

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd2;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_MUL,
        ST_START,
        ST_DIV,
        ST_SUM
    } t_state;

    typedef struct packed {
        logic pix_take;
        logic mul_go;
        logic div_start;
        logic sum_load;
    } t_dp_cmd;

    typedef struct packed {
        logic frame_end;
        logic dim_err;
        logic div_busy;
    } t_dp_sts;

    typedef struct packed {
        logic                 frame_summary;
        logic                 dimension_error;
        logic [31:0]          diff_rgba;
        logic [7:0]           heat_level;
        logic [CNT_W-1:0]     changed_count;
        logic [POS_W-1:0]     box_min_x;
        logic [POS_W-1:0]     box_min_y;
        logic [POS_W-1:0]     box_max_x;
        logic [POS_W-1:0]     box_max_y;
        logic                 has_changes;
        logic [15:0]          mean_abs_error_q8;
        logic [QUOT_W-1:0]    changed_ratio_q16;
    } t_out_item;

endpackage
`default_nettype wire

/* design/rfdm_in_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rfdm_in_if: pixel pair input channel
// Carries valid, ready and one expected and one actual RGBA pixel.
// ----------------------------------------------------------------------------
interface rfdm_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] expected_pixel;
    logic [31:0] actual_pixel;

    modport source (output valid, output expected_pixel, output actual_pixel, input ready);
    modport sink (input valid, input expected_pixel, input actual_pixel, output ready);
endinterface
`default_nettype wire

/* design/rfdm_out_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rfdm_out_if: result output channel
// Carries valid, ready and the fields of one pixel or summary result.
// ----------------------------------------------------------------------------
interface rfdm_out_if;
    import rfdm_pkg::*;
    logic              valid;
    logic              ready;
    logic              frame_summary;
    logic              dimension_error;
    logic [31:0]       diff_rgba;
    logic [7:0]        heat_level;
    logic [CNT_W-1:0]  changed_count;
    logic [POS_W-1:0]  box_min_x;
    logic [POS_W-1:0]  box_min_y;
    logic [POS_W-1:0]  box_max_x;
    logic [POS_W-1:0]  box_max_y;
    logic              has_changes;
    logic [15:0]       mean_abs_error_q8;
    logic [QUOT_W-1:0] changed_ratio_q16;

    modport source (
        output valid, output frame_summary, output dimension_error, output diff_rgba,
        output heat_level, output changed_count, output box_min_x, output box_min_y,
        output box_max_x, output box_max_y, output has_changes,
        output mean_abs_error_q8, output changed_ratio_q16, input ready
    );
    modport sink (
        input valid, input frame_summary, input dimension_error, input diff_rgba,
        input heat_level, input changed_count, input box_min_x, input box_min_y,
        input box_max_x, input box_max_y, input has_changes,
        input mean_abs_error_q8, input changed_ratio_q16, output ready
    );
endinterface
`default_nettype wire

/* design/rfdm_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rfdm_div: restoring divider, one quotient bit per cycle
// Divides a 41-bit numerator by a nonzero 25-bit divisor and
// keeps the low 17 quotient bits plus a sticky flag for any higher bit.
// ----------------------------------------------------------------------------
module rfdm_div import rfdm_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [DIV_NUM_W-1:0] i_num,
    input  wire logic [PIX_W-1:0]     i_den,
    output logic                      o_busy,
    output logic [QUOT_W-1:0]         o_quot,
    output logic                      o_ovf
);

    logic                 r_busy;
    logic [STEP_W-1:0]    r_step;
    logic [DIV_NUM_W-1:0] r_num;
    logic [PIX_W-1:0]     r_den;
    logic [PIX_W-1:0]     r_rem;
    logic [QUOT_W-1:0]    r_quot;
    logic                 r_ovf;

    logic [PIX_W:0]       n_trial;
    logic [PIX_W:0]       n_diff;
    logic                 n_ge;
    logic [PIX_W-1:0]     n_rem;

    always_comb begin
        n_trial = {r_rem, r_num[DIV_NUM_W-1]};
        n_diff  = n_trial - {1'b0, r_den};
        n_ge    = n_trial >= {1'b0, r_den};
        n_rem   = n_ge ? n_diff[PIX_W-1:0] : n_trial[PIX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + STEP_W'(1);
            if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
            r_ovf  <= 1'b0;
        end else if (r_busy) begin
            r_num  <= {r_num[DIV_NUM_W-2:0], 1'b0};
            r_rem  <= n_rem;
            r_quot <= {r_quot[QUOT_W-2:0], n_ge};
            r_ovf  <= r_ovf | r_quot[QUOT_W-1];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;
    assign o_ovf  = r_ovf;

endmodule
`default_nettype wire

/* design/rfdm_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rfdm_datapath: configuration, per-pixel arithmetic and frame statistics
// Holds the registers, the running frame state, the pixel count multiplier,
// the two end-of-frame dividers and the output result register.
// ----------------------------------------------------------------------------
module rfdm_datapath import rfdm_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [DIM_W-1:0]     i_cfg_data,
    input  wire logic [31:0]          i_expected_pixel,
    input  wire logic [31:0]          i_actual_pixel,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_sts                   o_sts,
    output t_out_item                 o_item
);

    logic [DIM_W-1:0]  r_cfg_width;
    logic [DIM_W-1:0]  r_cfg_height;
    logic [7:0]        r_cfg_thr;

    logic [POS_W-1:0]  r_col;
    logic [POS_W-1:0]  r_row;
    logic [CNT_W-1:0]  r_changed;
    logic [POS_W-1:0]  r_min_x;
    logic [POS_W-1:0]  r_min_y;
    logic [POS_W-1:0]  r_max_x;
    logic [POS_W-1:0]  r_max_y;
    logic              r_any;
    logic [7:0]        r_fmax;
    logic [SUM_W-1:0]  r_sum;
    logic [PIX_W-1:0]  r_pixels;
    t_out_item         r_item;

    logic [POS_W-1:0]  n_col;
    logic [POS_W-1:0]  n_row;
    logic [CNT_W-1:0]  n_changed;
    logic [POS_W-1:0]  n_min_x;
    logic [POS_W-1:0]  n_min_y;
    logic [POS_W-1:0]  n_max_x;
    logic [POS_W-1:0]  n_max_y;
    logic              n_any;
    logic [7:0]        n_fmax;
    logic [SUM_W-1:0]  n_sum;
    t_out_item         n_item;

    logic [DIM_W-1:0]  w_eff;
    logic [DIM_W-1:0]  h_eff;
    logic [7:0]        delta [4];
    logic [7:0]        pmax;
    logic [9:0]        psum;
    logic              changed;
    logic              row_end;
    logic              frame_end;
    logic              dim_err;
    logic [PIX_W-1:0]  product;

    logic              mean_busy;
    logic              ratio_busy;
    logic [QUOT_W-1:0] mean_quot;
    logic [QUOT_W-1:0] ratio_quot;
    logic              mean_ovf;
    logic              ratio_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= DIM_W'(1);
            r_cfg_height <= DIM_W'(1);
            r_cfg_thr    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_cfg_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_cfg_height <= i_cfg_data;
                CFG_THRESHOLD:    r_cfg_thr    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_eff = (r_cfg_width > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : r_cfg_width;
        h_eff = (r_cfg_height > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : r_cfg_height;
        dim_err = (w_eff == '0) || (h_eff == '0);
        row_end = ({1'b0, r_col} + DIM_W'(1)) >= w_eff;
        frame_end = row_end && (({1'b0, r_row} + DIM_W'(1)) >= h_eff);
        product = PIX_W'(w_eff) * PIX_W'(h_eff);

        for (int c = 0; c < 4; c++) begin
            delta[c] = (i_expected_pixel[8*c +: 8] > i_actual_pixel[8*c +: 8])
                     ? i_expected_pixel[8*c +: 8] - i_actual_pixel[8*c +: 8]
                     : i_actual_pixel[8*c +: 8] - i_expected_pixel[8*c +: 8];
        end
        pmax = delta[0];
        for (int c = 1; c < 4; c++) begin
            if (delta[c] > pmax) begin
                pmax = delta[c];
            end
        end
        psum = 10'(delta[0]) + 10'(delta[1]) + 10'(delta[2]) + 10'(delta[3]);
        changed = pmax > r_cfg_thr;
    end

    always_comb begin
        n_col     = r_col;
        n_row     = r_row;
        n_changed = r_changed;
        n_min_x   = r_min_x;
        n_min_y   = r_min_y;
        n_max_x   = r_max_x;
        n_max_y   = r_max_y;
        n_any     = r_any;
        n_fmax    = r_fmax;
        n_sum     = r_sum;
        n_item    = r_item;

        if (i_cmd.pix_take) begin
            n_item = '0;
            if (dim_err) begin
                n_item.frame_summary   = 1'b1;
                n_item.dimension_error = 1'b1;
            end else begin
                n_item.diff_rgba = {delta[3], delta[2], delta[1], delta[0]};
                n_sum = r_sum + SUM_W'(psum);
                if (pmax > r_fmax) begin
                    n_fmax = pmax;
                end
                if (changed) begin
                    n_item.heat_level = pmax;
                    n_changed = r_changed + CNT_W'(1);
                    if (!r_any) begin
                        n_min_x = r_col;
                        n_max_x = r_col;
                        n_min_y = r_row;
                        n_max_y = r_row;
                        n_any   = 1'b1;
                    end else begin
                        if (r_col < r_min_x) n_min_x = r_col;
                        if (r_row < r_min_y) n_min_y = r_row;
                        if (r_col > r_max_x) n_max_x = r_col;
                        if (r_row > r_max_y) n_max_y = r_row;
                    end
                end
                if (!row_end) begin
                    n_col = r_col + POS_W'(1);
                end else begin
                    n_col = '0;
                    if (!frame_end) begin
                        n_row = r_row + POS_W'(1);
                    end
                end
            end
        end else if (i_cmd.sum_load) begin
            n_item = '0;
            n_item.frame_summary = 1'b1;
            n_item.heat_level    = r_fmax;
            n_item.changed_count = r_changed;
            if (r_any) begin
                n_item.box_min_x   = r_min_x;
                n_item.box_min_y   = r_min_y;
                n_item.box_max_x   = r_max_x;
                n_item.box_max_y   = r_max_y;
                n_item.has_changes = 1'b1;
            end
            n_item.mean_abs_error_q8 = (mean_ovf || (mean_quot > MEAN_MAX))
                                     ? MEAN_MAX[15:0] : mean_quot[15:0];
            n_item.changed_ratio_q16 = (ratio_ovf || (ratio_quot > RATIO_MAX))
                                     ? RATIO_MAX : ratio_quot;
            n_col     = '0;
            n_row     = '0;
            n_changed = '0;
            n_min_x   = '0;
            n_min_y   = '0;
            n_max_x   = '0;
            n_max_y   = '0;
            n_any     = 1'b0;
            n_fmax    = '0;
            n_sum     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_changed <= '0;
            r_min_x   <= '0;
            r_min_y   <= '0;
            r_max_x   <= '0;
            r_max_y   <= '0;
            r_any     <= 1'b0;
            r_fmax    <= '0;
            r_sum     <= '0;
        end else begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_changed <= n_changed;
            r_min_x   <= n_min_x;
            r_min_y   <= n_min_y;
            r_max_x   <= n_max_x;
            r_max_y   <= n_max_y;
            r_any     <= n_any;
            r_fmax    <= n_fmax;
            r_sum     <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        if (i_cmd.mul_go) begin
            r_pixels <= product;
        end
    end

    rfdm_div u_mean_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   ({r_sum, 6'b0}),
        .i_den   (r_pixels),
        .o_busy  (mean_busy),
        .o_quot  (mean_quot),
        .o_ovf   (mean_ovf)
    );

    rfdm_div u_ratio_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   ({r_changed, 16'b0}),
        .i_den   (r_pixels),
        .o_busy  (ratio_busy),
        .o_quot  (ratio_quot),
        .o_ovf   (ratio_ovf)
    );

    always_comb begin
        o_sts.frame_end = frame_end;
        o_sts.dim_err   = dim_err;
        o_sts.div_busy  = mean_busy | ratio_busy;
    end

    assign o_item = r_item;

endmodule
`default_nettype wire

/* design/rfdm_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rfdm_ctrl: sequencing controller
// Runs the input and output handshakes, steps the datapath per pixel and
// sequences the pixel count product, the divisions and the summary result.
// ----------------------------------------------------------------------------
module rfdm_ctrl import rfdm_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        out_free   = !r_out_valid || i_out_ready;
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_RUN: begin
                o_in_ready = out_free;
                if (i_in_valid && out_free) begin
                    o_cmd.pix_take = 1'b1;
                    if (!i_sts.dim_err && i_sts.frame_end) begin
                        n_state = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                o_cmd.mul_go = 1'b1;
                n_state = ST_START;
            end
            ST_START: begin
                o_cmd.div_start = 1'b1;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (!i_sts.div_busy) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                if (out_free) begin
                    o_cmd.sum_load = 1'b1;
                    n_state = ST_RUN;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase

        if (o_cmd.pix_take || o_cmd.sum_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTH
    a_load_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.pix_take || o_cmd.sum_load) |-> (!r_out_valid || i_out_ready))
        else $error("Result register loaded while holding an untaken result.");

    a_mul_after_last_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |-> $past(o_cmd.pix_take))
        else $error("Summary sequence started without an accepted last pixel.");

    a_div_before_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |=> i_sts.div_busy)
        else $error("Dividers did not start.");

    a_summary_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SUM) |-> !i_sts.div_busy)
        else $error("Summary taken while the dividers are still running.");
`endif

endmodule
`default_nettype wire

/* design/rgba_frame_diff_metrics.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rgba_frame_diff_metrics: per-pixel RGBA difference and frame statistics
// Compares expected and actual RGBA pixels in raster order and reports the
// per-channel absolute differences, a thresholded heat level and, after the
// last pixel of each frame, a summary with the changed bounding box, counts,
// mean absolute error and changed ratio.
// ----------------------------------------------------------------------------
// Within a frame the block accepts one pixel per cycle while the output keeps
// up and returns one pixel result for each; a new pixel is taken in the
// same cycle that the previous result leaves the output register. After the
// last pixel of a frame the input stalls, plus any output backpressure, while
// the controller forms the width times height product, starts the dividers,
// waits for the two restoring dividers that produce one quotient bit per
// cycle to finish, and loads the summary result. With a zero width or height
// every pixel yields one error result and the frame statistics do not move.
module rgba_frame_diff_metrics import rfdm_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [DIM_W-1:0]     i_cfg_data,
    rfdm_in_if.sink                   i_in,
    rfdm_out_if.source                o_out
);

    t_dp_cmd   cmd;
    t_dp_sts   sts;
    t_out_item item;

    rfdm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    rfdm_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_expected_pixel (i_in.expected_pixel),
        .i_actual_pixel   (i_in.actual_pixel),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_item           (item)
    );

    assign o_out.frame_summary     = item.frame_summary;
    assign o_out.dimension_error   = item.dimension_error;
    assign o_out.diff_rgba         = item.diff_rgba;
    assign o_out.heat_level        = item.heat_level;
    assign o_out.changed_count     = item.changed_count;
    assign o_out.box_min_x         = item.box_min_x;
    assign o_out.box_min_y         = item.box_min_y;
    assign o_out.box_max_x         = item.box_max_x;
    assign o_out.box_max_y         = item.box_max_y;
    assign o_out.has_changes       = item.has_changes;
    assign o_out.mean_abs_error_q8 = item.mean_abs_error_q8;
    assign o_out.changed_ratio_q16 = item.changed_ratio_q16;

endmodule
`default_nettype wire

/* tb/sv/rgba_frame_diff_metrics_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgba_frame_diff_metrics_tb: self-checking bench for the frame diff block
// Streams expected/actual pixel pairs through the block under random flow
// control and checks every pixel result, dimension error and frame summary
// against a cycle-free model of the frame statistics kept in the bench.
// ----------------------------------------------------------------------------
module rgba_frame_diff_metrics_tb;
    import rfdm_pkg::*;

    localparam int CLK_HALF_NS   = 6;
    localparam int RESET_CYCLES  = 9;
    localparam int RANDOM_PIXELS = 1000;
    localparam int HOLD_OFF_LEN  = 300;
    localparam int DRAIN_LIMIT   = 100000;
    localparam int OVERSIZE_RUN  = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [DIM_W-1:0]     i_cfg_data;

    rfdm_in_if  pix_if ();
    rfdm_out_if res_if ();

    rgba_frame_diff_metrics dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (pix_if),
        .o_out       (res_if)
    );

    always begin
        #CLK_HALF_NS i_clk = 1'b1;
        #CLK_HALF_NS i_clk = 1'b0;
    end

    logic [DIM_W-1:0] cfg_width;
    logic [DIM_W-1:0] cfg_height;
    logic [7:0]       cfg_thresh;

    int unsigned      col_pos;
    int unsigned      row_pos;
    logic [CNT_W-1:0] changes_seen;
    int unsigned      box_x_lo;
    int unsigned      box_y_lo;
    int unsigned      box_x_hi;
    int unsigned      box_y_hi;
    bit               any_change;
    logic [7:0]       peak_delta;
    logic [SUM_W-1:0] delta_total;

    t_out_item   awaited_metrics[$];
    int unsigned frames_predicted;
    int unsigned pixels_sent;
    int unsigned results_seen;
    int unsigned summaries_seen;
    int unsigned dim_errors_seen;
    int unsigned mismatches;

    bit          src_gaps_on;
    bit          sink_stalls_on;
    int unsigned hold_off_cycles;

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] make_actual(input logic [31:0] exp_px);
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                return exp_px;
            end
            3, 4, 5: begin
                return exp_px ^ ($urandom & 32'h0303_0303);
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    function automatic void clear_frame_stats();
        col_pos      = 0;
        row_pos      = 0;
        changes_seen = '0;
        box_x_lo     = 0;
        box_y_lo     = 0;
        box_x_hi     = 0;
        box_y_hi     = 0;
        any_change   = 1'b0;
        peak_delta   = '0;
        delta_total  = '0;
    endfunction

    task automatic compute_pixel_metrics(input logic [31:0] exp_px, input logic [31:0] act_px);
        t_out_item   px_res;
        t_out_item   sum_res;
        int unsigned w;
        int unsigned h;
        logic [7:0]  ch_e;
        logic [7:0]  ch_a;
        logic [7:0]  d;
        logic [7:0]  pmax;
        logic [63:0] area;
        logic [63:0] mean;
        logic [63:0] ratio;
        w = (cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
        h = (cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : cfg_height;
        px_res  = '0;
        sum_res = '0;
        if (w == 0 || h == 0) begin
            px_res.frame_summary   = 1'b1;
            px_res.dimension_error = 1'b1;
            awaited_metrics.push_back(px_res);
            return;
        end
        pmax = '0;
        for (int c = 0; c < 4; c++) begin
            ch_e = exp_px[8*c +: 8];
            ch_a = act_px[8*c +: 8];
            d = (ch_e > ch_a) ? ch_e - ch_a : ch_a - ch_e;
            px_res.diff_rgba[8*c +: 8] = d;
            delta_total += SUM_W'(d);
            if (d > pmax) begin
                pmax = d;
            end
        end
        if (pmax > peak_delta) begin
            peak_delta = pmax;
        end
        if (pmax > cfg_thresh) begin
            px_res.heat_level = pmax;
            changes_seen++;
            if (!any_change) begin
                box_x_lo   = col_pos;
                box_x_hi   = col_pos;
                box_y_lo   = row_pos;
                box_y_hi   = row_pos;
                any_change = 1'b1;
            end else begin
                if (col_pos < box_x_lo) box_x_lo = col_pos;
                if (row_pos < box_y_lo) box_y_lo = row_pos;
                if (col_pos > box_x_hi) box_x_hi = col_pos;
                if (row_pos > box_y_hi) box_y_hi = row_pos;
            end
        end
        awaited_metrics.push_back(px_res);

        if (col_pos + 1 < w) begin
            col_pos++;
            return;
        end
        col_pos = 0;
        if (row_pos + 1 < h) begin
            row_pos++;
            return;
        end

        area  = 64'(w) * 64'(h);
        mean  = (64'(delta_total) << 6) / area;
        ratio = (64'(changes_seen) << 16) / area;
        if (mean > 64'(MEAN_MAX)) mean = 64'(MEAN_MAX);
        if (ratio > 64'(RATIO_MAX)) ratio = 64'(RATIO_MAX);
        sum_res.frame_summary     = 1'b1;
        sum_res.heat_level        = peak_delta;
        sum_res.changed_count     = changes_seen;
        sum_res.has_changes       = any_change;
        sum_res.mean_abs_error_q8 = mean[15:0];
        sum_res.changed_ratio_q16 = ratio[QUOT_W-1:0];
        if (any_change) begin
            sum_res.box_min_x = POS_W'(box_x_lo);
            sum_res.box_min_y = POS_W'(box_y_lo);
            sum_res.box_max_x = POS_W'(box_x_hi);
            sum_res.box_max_y = POS_W'(box_y_hi);
        end
        awaited_metrics.push_back(sum_res);
        frames_predicted++;
        clear_frame_stats();
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_FRAME_WIDTH: begin
                cfg_width = data;
            end
            CFG_FRAME_HEIGHT: begin
                cfg_height = data;
            end
            CFG_THRESHOLD: begin
                cfg_thresh = data[7:0];
            end
            default: begin
            end
        endcase
    endtask

    task automatic set_geometry(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                input logic [DIM_W-1:0] thr_data);
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
        write_reg(CFG_THRESHOLD, thr_data);
    endtask

    // Valid stays high after a transaction so back-to-back pixels need no
    // extra edge; a source gap or drain_results lowers it before a pause.
    task automatic send_pixel(input logic [31:0] exp_px, input logic [31:0] act_px);
        int unsigned gap;
        gap = src_gaps_on ? pick_gap() : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pix_if.valid          <= 1'b1;
        pix_if.expected_pixel <= exp_px;
        pix_if.actual_pixel   <= act_px;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        compute_pixel_metrics(exp_px, act_px);
        pixels_sent++;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        pix_if.valid <= 1'b0;
        while (awaited_metrics.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic test_pixel_extremes();
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
        send_pixel(32'h0000_0000, 32'h0000_0000);
        send_pixel(32'h0000_0000, 32'hFFFF_FFFF);
        send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
        send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pixel(32'h807F_01FE, 32'h7F80_FE01);
        drain_results();
    endtask

    task automatic test_threshold_extremes();
        set_geometry(13'd2, 13'd2, 13'h1FFF);
        send_pixel(32'h0000_0000, 32'hFFFF_FFFF);
        send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
        send_pixel($urandom, $urandom);
        send_pixel($urandom, $urandom);
        drain_results();
        write_reg(CFG_THRESHOLD, 13'h1F00);
        send_pixel(32'h5A5A_5A5A, 32'h5A5A_5A5A);
        send_pixel(32'h0000_0000, 32'h0100_0000);
        send_pixel(32'hC3C3_C3C3, 32'hC3C3_C3C3);
        send_pixel(32'h0000_00FF, 32'h0000_00FE);
        drain_results();
    endtask

    task automatic test_zero_dimension();
        set_geometry(13'd2, 13'd2, 13'd10);
        send_pixel(32'h1020_3040, 32'h1020_30FF);
        drain_results();
        write_reg(CFG_FRAME_WIDTH, 13'd0);
        send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
        send_pixel($urandom, $urandom);
        drain_results();
        write_reg(CFG_FRAME_WIDTH, 13'd2);
        write_reg(CFG_FRAME_HEIGHT, 13'd0);
        send_pixel($urandom, $urandom);
        drain_results();
        write_reg(CFG_FRAME_HEIGHT, 13'd2);
        write_reg(CFG_SPARE_INDEX, 13'd0);
        send_pixel(32'h0000_0000, 32'h0000_0000);
        send_pixel(32'hAB00_0000, 32'h0000_0000);
        send_pixel(32'h0000_0011, 32'h0000_0000);
        drain_results();
    endtask

    // Shrinking the frame after two full rows leaves more changed pixels than
    // the final geometry holds, which drives the changed ratio and the mean to saturation.
    task automatic test_geometry_change();
        set_geometry(13'd2, 13'd4, 13'd0);
        repeat (4) send_pixel(32'h0000_0000, 32'hFFFF_FFFF);
        drain_results();
        write_reg(CFG_FRAME_WIDTH, 13'd1);
        write_reg(CFG_FRAME_HEIGHT, 13'd1);
        send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
        drain_results();
    endtask

    task automatic test_output_hold_off();
        logic [31:0] exp_px;
        set_geometry(13'd5, 13'd4, 13'd16);
        src_gaps_on     = 1'b0;
        sink_stalls_on  = 1'b0;
        hold_off_cycles = HOLD_OFF_LEN;
        repeat (10) begin
            exp_px = $urandom;
            send_pixel(exp_px, make_actual(exp_px));
        end
        drain_results();
        repeat ($urandom_range(1, 50)) @(negedge i_clk);
        repeat (10) begin
            exp_px = $urandom;
            send_pixel(exp_px, make_actual(exp_px));
        end
        drain_results();
    endtask

    task automatic test_random_frames();
        int unsigned w;
        int unsigned h;
        int unsigned thr;
        int unsigned break_at;
        int unsigned sent;
        int unsigned first_frame;
        logic [31:0] exp_px;
        while (pixels_sent < RANDOM_PIXELS) begin
            case ($urandom_range(0, 9))
                0: begin
                    w = 1;
                    h = 1;
                end
                9: begin
                    w = $urandom_range(16, 64);
                    h = $urandom_range(1, 4);
                end
                default: begin
                    w = $urandom_range(1, 8);
                    h = $urandom_range(1, 6);
                end
            endcase
            case ($urandom_range(0, 7))
                0: thr = 0;
                1: thr = 255;
                default: thr = $urandom_range(0, 255);
            endcase
            set_geometry(DIM_W'(w), DIM_W'(h), {5'($urandom), 8'(thr)});
            src_gaps_on    = ($urandom_range(0, 3) != 0);
            sink_stalls_on = ($urandom_range(0, 3) != 0);
            break_at    = ($urandom_range(0, 5) == 0) ? $urandom_range(0, w * h - 1) : w * h;
            first_frame = frames_predicted;
            sent        = 0;
            while (frames_predicted == first_frame) begin
                if (sent == break_at) begin
                    drain_results();
                    case ($urandom_range(0, 2))
                        0: begin
                            if ($urandom_range(0, 1) != 0) begin
                                write_reg(CFG_FRAME_WIDTH, '0);
                            end else begin
                                write_reg(CFG_FRAME_HEIGHT, '0);
                            end
                            repeat ($urandom_range(1, 3)) send_pixel($urandom, $urandom);
                            drain_results();
                            write_reg(CFG_FRAME_WIDTH, DIM_W'(w));
                            write_reg(CFG_FRAME_HEIGHT, DIM_W'(h));
                        end
                        1: begin
                            write_reg(CFG_FRAME_WIDTH, DIM_W'($urandom_range(1, 6)));
                            write_reg(CFG_FRAME_HEIGHT, DIM_W'($urandom_range(1, 6)));
                        end
                        default: begin
                            repeat ($urandom_range(1, 60)) @(negedge i_clk);
                        end
                    endcase
                end
                exp_px = $urandom;
                send_pixel(exp_px, make_actual(exp_px));
                sent++;
            end
            drain_results();
        end
        drain_results();
    endtask

    // Registers above the size limit clamp to 4096, so a long run of pixels
    // stays on one row, or walks down one column, until a smaller geometry
    // ends the frame.
    task automatic test_oversized_geometry();
        logic [31:0] exp_px;
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
        set_geometry(13'h1FFF, 13'h1FFF, 13'd20);
        for (int i = 0; i < OVERSIZE_RUN; i++) begin
            exp_px = $urandom;
            if (i % 7 == 5) begin
                send_pixel(exp_px, ~exp_px);
            end else begin
                send_pixel(exp_px, exp_px ^ ($urandom & 32'h0707_0707));
            end
        end
        drain_results();
        set_geometry(13'd1, 13'd1, 13'd20);
        exp_px = $urandom;
        send_pixel(exp_px, ~exp_px);
        drain_results();
        set_geometry(13'd1, 13'h1FFF, 13'd20);
        for (int i = 0; i < OVERSIZE_RUN; i++) begin
            exp_px = $urandom;
            if (i % 9 == 7) begin
                send_pixel(exp_px, ~exp_px);
            end else begin
                send_pixel(exp_px, exp_px ^ ($urandom & 32'h0707_0707));
            end
        end
        drain_results();
        write_reg(CFG_FRAME_HEIGHT, 13'd3);
        exp_px = $urandom;
        send_pixel(exp_px, ~exp_px);
        drain_results();
    endtask

    initial begin : result_ready_gen
        int unsigned stall;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_cycles != 0) begin
                res_if.ready <= 1'b0;
                repeat (hold_off_cycles) @(negedge i_clk);
                hold_off_cycles = 0;
                res_if.ready <= 1'b1;
            end else if (sink_stalls_on && $urandom_range(0, 3) == 0) begin
                stall = pick_gap();
                if (stall != 0) begin
                    res_if.ready <= 1'b0;
                    repeat (stall) @(negedge i_clk);
                end
                res_if.ready <= 1'b1;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            results_seen++;
            if (awaited_metrics.size() == 0) begin
                $error("result transaction arrived with no prediction pending");
                mismatches++;
            end else begin
                want = awaited_metrics.pop_front();
                if (want.dimension_error) begin
                    dim_errors_seen++;
                end else if (want.frame_summary) begin
                    summaries_seen++;
                end
                compare_field("frame_summary", want.frame_summary, res_if.frame_summary);
                compare_field("dimension_error", want.dimension_error, res_if.dimension_error);
                compare_field("diff_rgba", want.diff_rgba, res_if.diff_rgba);
                compare_field("heat_level", want.heat_level, res_if.heat_level);
                compare_field("changed_count", want.changed_count, res_if.changed_count);
                compare_field("box_min_x", want.box_min_x, res_if.box_min_x);
                compare_field("box_min_y", want.box_min_y, res_if.box_min_y);
                compare_field("box_max_x", want.box_max_x, res_if.box_max_x);
                compare_field("box_max_y", want.box_max_y, res_if.box_max_y);
                compare_field("has_changes", want.has_changes, res_if.has_changes);
                compare_field("mean_abs_error_q8", want.mean_abs_error_q8,
                              res_if.mean_abs_error_q8);
                compare_field("changed_ratio_q16", want.changed_ratio_q16,
                              res_if.changed_ratio_q16);
            end
        end
    end

    initial begin
        #100_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin : run_tests
        int unsigned waited;
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_index           = '0;
        i_cfg_data            = '0;
        pix_if.valid          = 1'b0;
        pix_if.expected_pixel = '0;
        pix_if.actual_pixel   = '0;
        src_gaps_on           = 1'b0;
        sink_stalls_on        = 1'b0;
        hold_off_cycles       = 0;
        frames_predicted      = 0;
        pixels_sent           = 0;
        results_seen          = 0;
        summaries_seen        = 0;
        dim_errors_seen       = 0;
        mismatches            = 0;
        cfg_width             = 13'd1;
        cfg_height            = 13'd1;
        cfg_thresh            = 8'd0;
        clear_frame_stats();

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_pixel_extremes();
        test_threshold_extremes();
        test_zero_dimension();
        test_geometry_change();
        test_output_hold_off();
        test_random_frames();
        test_oversized_geometry();

        @(negedge i_clk);
        pix_if.valid <= 1'b0;
        waited = 0;
        while (awaited_metrics.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (awaited_metrics.size() != 0) begin
            $error("%0d predicted results never arrived", awaited_metrics.size());
            mismatches++;
        end
        repeat (60) @(posedge i_clk);

        $display("Run covered %0d pixel transactions and %0d result transactions, %0d of them",
                 pixels_sent, results_seen, summaries_seen + dim_errors_seen);
        $display("frame summaries or dimension errors, from 1x1 frames to oversized registers.");
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
design/rfdm_pkg.sv
design/rfdm_in_if.sv
design/rfdm_out_if.sv
design/rfdm_div.sv
design/rfdm_datapath.sv
design/rfdm_ctrl.sv
design/rgba_frame_diff_metrics.sv
tb/sv/rgba_frame_diff_metrics_tb.sv
